@@ hdl/hcb_pkg.sv @@
`timescale 1ns / 1ps
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int FREQ_BITS_DEF   = 20;
  localparam int SYM_W           = 8;
  localparam int CODE_W          = 15;
  localparam int LEN_W           = 4;

  typedef struct packed {
    logic load;
    logic load_last;
    logic scan_init;
    logic scan_en;
    logic merge;
    logic walk_init;
    logic walk_step;
    logic walk_pop;
  } hcb_cmd_t;

  typedef struct packed {
    logic build_done;
    logic scan_last;
    logic is_leaf;
    logic stack_empty;
  } hcb_status_t;

endpackage

@@ hdl/hcb_ctrl.sv @@
`timescale 1ns / 1ps
module hcb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_entry,
  input  hcb_pkg::hcb_status_t sts,
  output hcb_pkg::hcb_cmd_t   cmd,
  output logic                busy
);
  import hcb_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_CHK    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_MERGE  = 3'd4;
  localparam logic [2:0] S_WFETCH = 3'd5;
  localparam logic [2:0] S_WSTEP  = 3'd6;
  localparam logic [2:0] S_WPOP   = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_LOAD);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_entry) begin
            cmd.load_last = 1'b1;
            state_nxt     = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts.build_done) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WFETCH;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_MERGE;
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = S_CHK;
      end
      S_WFETCH: state_nxt = S_WSTEP;
      S_WSTEP: begin
        cmd.walk_step = 1'b1;
        if (!sts.is_leaf) state_nxt = S_WFETCH;
        else if (sts.stack_empty) state_nxt = S_LOAD;
        else state_nxt = S_WPOP;
      end
      S_WPOP: begin
        cmd.walk_pop = 1'b1;
        state_nxt    = S_WFETCH;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else state_r <= state_nxt;
  end

endmodule

@@ hdl/hcb_datapath.sv @@
`timescale 1ns / 1ps
module hcb_datapath #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
  parameter int FREQ_BITS   = hcb_pkg::FREQ_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcb_pkg::hcb_cmd_t           cmd,
  output hcb_pkg::hcb_status_t        sts,
  input  logic [hcb_pkg::SYM_W-1:0]   in_symbol,
  input  logic [FREQ_BITS-1:0]        in_frequency,
  output logic                        out_valid,
  output logic [hcb_pkg::SYM_W-1:0]   out_symbol,
  output logic [hcb_pkg::CODE_W-1:0]  out_code_bits,
  output logic [hcb_pkg::LEN_W-1:0]   out_code_length,
  output logic                        out_last_code
);
  import hcb_pkg::*;

  localparam int N   = 2 * MAX_SYMBOLS - 1;
  localparam int CW  = $clog2(MAX_SYMBOLS + 1);
  localparam int LW  = $clog2(MAX_SYMBOLS);
  localparam int NIW = $clog2(N);
  localparam int TW  = $clog2(N + 1);
  localparam int WW  = FREQ_BITS + $clog2(MAX_SYMBOLS);

  logic [SYM_W-1:0]   sym_mem [MAX_SYMBOLS];
  logic [WW-1:0]      w_mem   [N];
  logic [2*NIW-1:0]   ch_mem  [N];
  logic [NIW+CODE_W+LEN_W-1:0] stk_mem [MAX_SYMBOLS];

  logic [N-1:0]  active_r;
  logic [CW-1:0] count_r;
  logic [TW-1:0] total_r;
  logic [NIW-1:0] scan_idx_r, cmp_idx_r;
  logic          cmp_v_r;
  logic [WW-1:0] rd_w_r;
  logic          m1_v_r, m2_v_r;
  logic [NIW-1:0] m1_i_r, m2_i_r;
  logic [WW-1:0] m1_w_r, m2_w_r;

  logic [NIW-1:0]    cur_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  logic [CW-1:0]     sp_r;
  logic [SYM_W-1:0]  sym_rd_r;
  logic [2*NIW-1:0]  ch_rd_r;
  logic [NIW+CODE_W+LEN_W-1:0] stk_rd_r;

  logic          room;
  logic [CW:0]   last_node;
  logic [CODE_W-1:0] code_sh;
  logic [LEN_W-1:0]  len_inc;
  logic [WW-1:0] sum_w;
  logic          lt1, lt2, cand;

  assign room      = (count_r < CW'(MAX_SYMBOLS));
  assign last_node = {count_r, 1'b0} - (CW+1)'(1);
  assign code_sh   = {code_r[CODE_W-2:0], 1'b0};
  assign len_inc   = len_r + LEN_W'(1);
  assign sum_w     = m1_w_r + m2_w_r;

  assign sts.build_done  = (total_r == TW'(last_node));
  assign sts.scan_last   = ((TW'(scan_idx_r) + TW'(1)) == total_r);
  assign sts.is_leaf     = (TW'(cur_r) < TW'(count_r));
  assign sts.stack_empty = (sp_r == '0);

  assign cand = cmp_v_r && active_r[cmp_idx_r];
  assign lt1  = !m1_v_r || (rd_w_r < m1_w_r);
  assign lt2  = !m2_v_r || (rd_w_r < m2_w_r);

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      sym_mem[count_r[LW-1:0]] <= in_symbol;
      w_mem[NIW'(count_r)]     <= WW'(in_frequency);
    end else if (cmd.merge) begin
      w_mem[NIW'(total_r)] <= sum_w;
    end
    if (cmd.merge) ch_mem[NIW'(total_r)] <= {m1_i_r, m2_i_r};
    if (cmd.walk_step && !sts.is_leaf)
      stk_mem[sp_r[LW-1:0]] <= {ch_rd_r[NIW-1:0], code_sh | CODE_W'(1), len_inc};
    rd_w_r   <= w_mem[scan_idx_r];
    sym_rd_r <= sym_mem[cur_r[LW-1:0]];
    ch_rd_r  <= ch_mem[cur_r];
    stk_rd_r <= stk_mem[LW'(sp_r - CW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= '0;
      count_r       <= '0;
      total_r       <= '0;
      cmp_v_r       <= 1'b0;
      m1_v_r        <= 1'b0;
      m2_v_r        <= 1'b0;
      sp_r          <= '0;
      out_valid     <= 1'b0;
      out_last_code <= 1'b0;
    end else begin
      cmp_v_r   <= cmd.scan_en;
      cmp_idx_r <= scan_idx_r;
      out_valid <= 1'b0;
      if (cmd.load && room) begin
        active_r[NIW'(count_r)] <= 1'b1;
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_last) total_r <= TW'(count_r) + TW'(room);
      if (cmd.scan_init) begin
        scan_idx_r <= '0;
        m1_v_r     <= 1'b0;
        m2_v_r     <= 1'b0;
      end
      if (cmd.scan_en) scan_idx_r <= scan_idx_r + NIW'(1);
      // Strict compares in index order keep the earlier node on equal weights.
      if (cand) begin
        if (lt1) begin
          m2_v_r <= m1_v_r;
          m2_i_r <= m1_i_r;
          m2_w_r <= m1_w_r;
          m1_v_r <= 1'b1;
          m1_i_r <= cmp_idx_r;
          m1_w_r <= rd_w_r;
        end else if (lt2) begin
          m2_v_r <= 1'b1;
          m2_i_r <= cmp_idx_r;
          m2_w_r <= rd_w_r;
        end
      end
      if (cmd.merge) begin
        active_r[m1_i_r]          <= 1'b0;
        active_r[m2_i_r]          <= 1'b0;
        active_r[NIW'(total_r)]   <= 1'b1;
        total_r <= total_r + TW'(1);
      end
      if (cmd.walk_init) begin
        cur_r  <= NIW'(total_r - TW'(1));
        code_r <= '0;
        len_r  <= '0;
        sp_r   <= '0;
      end
      if (cmd.walk_step) begin
        if (sts.is_leaf) begin
          out_valid       <= 1'b1;
          out_symbol      <= sym_rd_r;
          out_code_bits   <= code_r;
          out_code_length <= len_r;
          out_last_code   <= sts.stack_empty;
          if (sts.stack_empty) begin
            active_r <= '0;
            count_r  <= '0;
          end else begin
            sp_r <= sp_r - CW'(1);
          end
        end else begin
          sp_r   <= sp_r + CW'(1);
          cur_r  <= ch_rd_r[2*NIW-1:NIW];
          code_r <= code_sh;
          len_r  <= len_inc;
        end
      end
      if (cmd.walk_pop) begin
        cur_r  <= stk_rd_r[NIW+CODE_W+LEN_W-1:CODE_W+LEN_W];
        code_r <= stk_rd_r[CODE_W+LEN_W-1:LEN_W];
        len_r  <= stk_rd_r[LEN_W-1:0];
      end
    end
  end

  a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge |-> (m1_v_r && m2_v_r && (m1_i_r != m2_i_r)))
    else $error("merge without two distinct active nodes");
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(N))
    else $error("node count beyond store depth");
  a_stack_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r < CW'(MAX_SYMBOLS))
    else $error("walk stack overflow");
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_code) |=> !out_valid)
    else $error("result after the final leaf");

endmodule

@@ hdl/huffman_code_builder.sv @@
`timescale 1ns / 1ps
// Huffman code builder. Symbol and frequency pairs are loaded one per cycle while busy is
// low; the pair with in_last_entry set ends the set and starts the build. Each of the
// leaves-1 merges scans the node store through its single read port, so the build grows
// quadratically with the number of symbols. The tree walk then fetches and steps through
// each internal node and each leaf, and after each leaf but the last pops the stack. One
// result per leaf comes out on out_valid for exactly one cycle, in pre-order with left
// children first; the receiver cannot stall, so every strobe must be captured. busy stays
// high from the last entry until the final leaf is reported.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
  parameter int FREQ_BITS   = hcb_pkg::FREQ_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [hcb_pkg::SYM_W-1:0]   in_symbol,
  input  logic [FREQ_BITS-1:0]        in_frequency,
  input  logic                        in_last_entry,
  output logic                        out_valid,
  output logic [hcb_pkg::SYM_W-1:0]   out_symbol,
  output logic [hcb_pkg::CODE_W-1:0]  out_code_bits,
  output logic [hcb_pkg::LEN_W-1:0]   out_code_length,
  output logic                        out_last_code
);
  import hcb_pkg::*;

  hcb_cmd_t    cmd;
  hcb_status_t sts;

  hcb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_entry (in_last_entry),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  hcb_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .FREQ_BITS   (FREQ_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_symbol       (in_symbol),
    .in_frequency    (in_frequency),
    .out_valid       (out_valid),
    .out_symbol      (out_symbol),
    .out_code_bits   (out_code_bits),
    .out_code_length (out_code_length),
    .out_last_code   (out_last_code)
  );

endmodule

@@ test/huffman_code_builder_tb.sv @@
`timescale 1ns / 1ps
module huffman_code_builder_tb;
  import hcb_pkg::*;

  localparam int NSYM = MAX_SYMBOLS_DEF;
  localparam int FBITS = FREQ_BITS_DEF;
  localparam int NODES = 2 * NSYM - 1;

  typedef struct {
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
  } leaf_code_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [SYM_W-1:0] in_symbol;
  logic [FBITS-1:0] in_frequency;
  logic in_last_entry;
  logic out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic [CODE_W-1:0] out_code_bits;
  logic [LEN_W-1:0] out_code_length;
  logic out_last_code;

  huffman_code_builder DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_symbol(in_symbol), .in_frequency(in_frequency), .in_last_entry(in_last_entry),
    .out_valid(out_valid), .out_symbol(out_symbol), .out_code_bits(out_code_bits),
    .out_code_length(out_code_length), .out_last_code(out_last_code)
  );

  // Predictor state: the set of loaded leaves.
  logic [SYM_W-1:0] set_symbols[NSYM];
  logic [23:0]      set_weights[NSYM];
  int               set_count;
  leaf_code_t       expected_codes[$];
  int               fail_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("huffman_code_builder regression: fail");
    $finish;
  end

  // Builds the tree over the loaded set and queues one code per leaf in pre-order.
  task automatic build_codes();
    logic [23:0] wt[NODES];
    int lchild[NODES];
    int rchild[NODES];
    bit act[NODES];
    int stk_node[NODES];
    logic [CODE_W-1:0] stk_code[NODES];
    int stk_len[NODES];
    int total, a, b, sp, n, first;
    leaf_code_t lc;
    total = set_count;
    for (int i = 0; i < NODES; i++) act[i] = (i < set_count);
    for (int i = 0; i < set_count; i++) wt[i] = set_weights[i];
    for (int m = 1; m < set_count; m++) begin
      a = -1;
      b = -1;
      for (int i = 0; i < total; i++)
        if (act[i] && (a < 0 || wt[i] < wt[a])) a = i;
      for (int i = 0; i < total; i++)
        if (act[i] && i != a && (b < 0 || wt[i] < wt[b])) b = i;
      wt[total] = wt[a] + wt[b];
      lchild[total] = a;
      rchild[total] = b;
      act[a] = 0;
      act[b] = 0;
      act[total] = 1;
      total++;
    end
    first = expected_codes.size();
    sp = 0;
    if (total > 0) begin
      stk_node[0] = total - 1;
      stk_code[0] = '0;
      stk_len[0] = 0;
      sp = 1;
    end
    while (sp > 0) begin
      sp--;
      n = stk_node[sp];
      if (n < set_count) begin
        lc.symbol = set_symbols[n];
        lc.code_bits = stk_code[sp];
        lc.code_length = LEN_W'(stk_len[sp]);
        lc.last_code = 1'b0;
        expected_codes.push_back(lc);
      end else begin
        stk_node[sp + 1] = lchild[n];
        stk_code[sp + 1] = {stk_code[sp][CODE_W-2:0], 1'b0};
        stk_len[sp + 1] = stk_len[sp] + 1;
        stk_node[sp] = rchild[n];
        stk_code[sp] = {stk_code[sp][CODE_W-2:0], 1'b1};
        stk_len[sp] = stk_len[sp] + 1;
        sp += 2;
      end
    end
    if (expected_codes.size() > first)
      expected_codes[expected_codes.size() - 1].last_code = 1'b1;
    set_count = 0;
  endtask

  // A gap drops start; with no gap the next entry follows at once.
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    start <= 1'b0;
    repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
  endtask

  task automatic send_entry(input logic [SYM_W-1:0] sym, input logic [FBITS-1:0] freq,
                            input logic last);
    start <= 1'b1;
    in_symbol <= sym;
    in_frequency <= freq;
    in_last_entry <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (set_count < NSYM) begin
      set_symbols[set_count] = sym;
      set_weights[set_count] = 24'(freq);
      set_count++;
    end
    if (last) build_codes();
    random_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_codes.size() > 0 || busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    leaf_code_t e;
    if (rst_n && out_valid) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected result symbol %0d", out_symbol);
        fail_count++;
      end else begin
        e = expected_codes.pop_front();
        if (out_symbol !== e.symbol) begin
          $error("out_symbol expected %0d actual %0d", e.symbol, out_symbol);
          fail_count++;
        end
        if (out_code_bits !== e.code_bits) begin
          $error("code_bits expected %h actual %h", e.code_bits, out_code_bits);
          fail_count++;
        end
        if (out_code_length !== e.code_length) begin
          $error("code_length expected %0d actual %0d", e.code_length, out_code_length);
          fail_count++;
        end
        if (out_last_code !== e.last_code) begin
          $error("last_code expected %0d actual %0d", e.last_code, out_last_code);
          fail_count++;
        end
      end
    end
  end

  task automatic test_single_symbol();
    send_entry(8'h00, '0, 1'b1);
    send_entry(8'hff, '1, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_entry(8'h7c, '1, 1'b0);
    send_entry(8'hff, '0, 1'b0);
    send_entry(8'h00, 20'h55555, 1'b0);
    send_entry(8'h7c, 20'haaaaa, 1'b1);
    // Equal weights exercise the earlier-node tie order.
    for (int i = 0; i < 4; i++) send_entry(8'h41, 20'd5, i == 3);
    drain();
  endtask

  task automatic test_overflowing_set();
    // Entries past the capacity are dropped; the final one still starts the build.
    for (int i = 0; i < NSYM + 2; i++)
      send_entry(SYM_W'(i), 20'd1 << (i % 20), i == NSYM + 1);
    drain();
  endtask

  task automatic test_random_sets();
    int items, n, kind;
    items = 0;
    while (items < 340) begin
      kind = $urandom_range(0, 9);
      n = (kind < 7) ? $urandom_range(2, 8) : $urandom_range(1, NSYM + 3);
      for (int i = 0; i < n; i++) begin
        send_entry(SYM_W'($urandom_range(0, 255)),
                   (kind == 0) ? FBITS'($urandom_range(0, 3)) :
                                 FBITS'($urandom_range(0, (1 << FBITS) - 1)),
                   i == n - 1);
        items++;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    fail_count = 0;
    set_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_symbol = '0;
    in_frequency = '0;
    in_last_entry = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_symbol();
    test_field_extremes();
    test_overflowing_set();
    test_random_sets();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_codes.size() == 0) begin
      $display("huffman_code_builder regression: pass");
    end else begin
      $display("huffman_code_builder regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hcb_pkg.sv
hdl/hcb_ctrl.sv
hdl/hcb_datapath.sv
hdl/huffman_code_builder.sv
test/huffman_code_builder_tb.sv
